// ===== design/rational_reduce_normalize_top_macros.svh =====
// ----------------------------------------------------------------------------
// rational_reduce_normalize_top_macros
// Assertion macros shared by the fraction reducer.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_REDUCE_NORMALIZE_TOP_MACROS_SVH
`define RATIONAL_REDUCE_NORMALIZE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RRN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrn assertion failed");

// next-cycle implication, disabled while in reset
`define RRN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrn assertion failed");

`endif

// ===== design/rrn_pkg.sv =====
// ----------------------------------------------------------------------------
// rrn_pkg
// Types, codes and constants of the fraction reducer.
// ----------------------------------------------------------------------------
package rrn_pkg;

  localparam int unsigned DefaultWidth = 64;
  localparam int unsigned FieldW       = 64;
  localparam int unsigned DenOutW      = 63;

  typedef enum logic [1:0] {
    ST_INT      = 2'd0,
    ST_RAT      = 2'd1,
    ST_UNREP    = 2'd2,
    ST_ZERO_DEN = 2'd3
  } rrn_status_e;

  typedef struct packed {
    logic signed [FieldW-1:0] num_in;
    logic signed [FieldW-1:0] den_in;
  } rrn_in_t;

  typedef struct packed {
    logic signed [FieldW-1:0] num_out;
    logic [DenOutW-1:0]       den_out;
    rrn_status_e              status;
  } rrn_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_COMMON,
    S_AODD,
    S_GCD,
    S_DIV,
    S_FIN,
    S_DONE
  } rrn_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic common_shift;
    logic save_shift;
    logic a_shift;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic capture;
  } rrn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic trivial;    // zero denominator or zero numerator
    logic both_even;
    logic a_even;
    logic b_zero;
    logic div_last;
  } rrn_stat_t;

endpackage

// ===== design/rrn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrn_ctrl
// Sequencer: gcd phases, bit-serial division, result strobe.
// ----------------------------------------------------------------------------
module rrn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  rrn_pkg::rrn_stat_t stat_i,
  output rrn_pkg::rrn_cmd_t  cmd_o,
  output logic              busy,
  output logic              strobe_o
);

  rrn_pkg::rrn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrn_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrn_pkg::S_IDLE: begin
        if (start) state_d = rrn_pkg::S_CHECK;
      end
      rrn_pkg::S_CHECK: begin
        state_d = stat_i.trivial ? rrn_pkg::S_FIN : rrn_pkg::S_COMMON;
      end
      rrn_pkg::S_COMMON: begin
        if (!stat_i.both_even) state_d = rrn_pkg::S_AODD;
      end
      rrn_pkg::S_AODD: begin
        if (!stat_i.a_even) state_d = rrn_pkg::S_GCD;
      end
      rrn_pkg::S_GCD: begin
        if (stat_i.b_zero) state_d = rrn_pkg::S_DIV;
      end
      rrn_pkg::S_DIV: begin
        if (stat_i.div_last) state_d = rrn_pkg::S_FIN;
      end
      rrn_pkg::S_FIN: begin
        state_d = rrn_pkg::S_DONE;
      end
      rrn_pkg::S_DONE: begin
        state_d = rrn_pkg::S_IDLE;
      end
      default: begin
        state_d = rrn_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    busy     = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      rrn_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      rrn_pkg::S_CHECK: begin
      end
      rrn_pkg::S_COMMON: begin
        cmd_o.common_shift = stat_i.both_even;
        cmd_o.save_shift   = !stat_i.both_even;
      end
      rrn_pkg::S_AODD: begin
        cmd_o.a_shift = stat_i.a_even;
      end
      rrn_pkg::S_GCD: begin
        cmd_o.gcd_step = !stat_i.b_zero;
        cmd_o.div_init = stat_i.b_zero;
      end
      rrn_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      rrn_pkg::S_FIN: begin
        cmd_o.capture = 1'b1;
      end
      rrn_pkg::S_DONE: begin
        strobe_o = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/rrn_dp.sv =====
// ----------------------------------------------------------------------------
// rrn_dp
// Datapath: magnitudes, binary gcd, two restoring dividers, result register.
// ----------------------------------------------------------------------------
module rrn_dp #(
  parameter int unsigned WIDTH = rrn_pkg::DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrn_pkg::rrn_in_t   in_i,
  input  rrn_pkg::rrn_cmd_t  cmd_i,
  output rrn_pkg::rrn_stat_t stat_o,
  output rrn_pkg::rrn_out_t  out_o
);

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] SignBit = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] One     = {{(WIDTH-1){1'b0}}, 1'b1};

  logic [WIDTH-1:0] a_q, b_q, nsh_q, dsh_q;
  logic [WIDTH-1:0] qn_q, qd_q, remn_q, remd_q;
  logic [CntW-1:0]  cnt_q;
  logic             dz_q, nz_q, sign_q;
  rrn_pkg::rrn_out_t res_q, res_d;

  // input magnitudes, upper bits ignored; the minimum maps to 2^(WIDTH-1)
  logic [WIDTH-1:0] nv, dv, nm, dm;
  assign nv = in_i.num_in[WIDTH-1:0];
  assign dv = in_i.den_in[WIDTH-1:0];
  assign nm = nv[WIDTH-1] ? (~nv + One) : nv;
  assign dm = dv[WIDTH-1] ? (~dv + One) : dv;

  // gcd step on odd a
  logic [WIDTH:0]   d_ab;
  logic [WIDTH-1:0] d_ba;
  assign d_ab = {1'b0, a_q} - {1'b0, b_q};
  assign d_ba = b_q - a_q;

  // divider trial subtracts
  logic [WIDTH:0] trial_n, trial_d, sub_n, sub_d;
  assign trial_n = {remn_q, qn_q[WIDTH-1]};
  assign trial_d = {remd_q, qd_q[WIDTH-1]};
  assign sub_n   = trial_n - {1'b0, a_q};
  assign sub_d   = trial_d - {1'b0, a_q};

  assign stat_o.trivial   = dz_q || nz_q;
  assign stat_o.both_even = !a_q[0] && !b_q[0];
  assign stat_o.a_even    = !a_q[0];
  assign stat_o.b_zero    = (b_q == '0);
  assign stat_o.div_last  = (cnt_q == CntW'(WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= nm;
      b_q    <= dm;
      nz_q   <= (nm == '0);
      dz_q   <= (dm == '0);
      sign_q <= nv[WIDTH-1] ^ dv[WIDTH-1];
    end
    if (cmd_i.common_shift) begin
      a_q <= a_q >> 1;
      b_q <= b_q >> 1;
    end
    // operands with the common power of two removed; the odd gcd divides both
    if (cmd_i.save_shift) begin
      nsh_q <= a_q;
      dsh_q <= b_q;
    end
    if (cmd_i.a_shift) begin
      a_q <= a_q >> 1;
    end
    if (cmd_i.gcd_step) begin
      if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (d_ab[WIDTH]) begin
        b_q <= d_ba;
      end else begin
        a_q <= b_q;
        b_q <= d_ab[WIDTH-1:0];
      end
    end
    if (cmd_i.div_init) begin
      qn_q   <= nsh_q;
      qd_q   <= dsh_q;
      remn_q <= '0;
      remd_q <= '0;
    end
    if (cmd_i.div_step) begin
      remn_q <= sub_n[WIDTH] ? trial_n[WIDTH-1:0] : sub_n[WIDTH-1:0];
      remd_q <= sub_d[WIDTH] ? trial_d[WIDTH-1:0] : sub_d[WIDTH-1:0];
      qn_q   <= {qn_q[WIDTH-2:0], !sub_n[WIDTH]};
      qd_q   <= {qd_q[WIDTH-2:0], !sub_d[WIDTH]};
    end
    if (cmd_i.capture) begin
      res_q <= res_d;
    end
  end

  logic [WIDTH-1:0]          num_w;
  logic [rrn_pkg::FieldW-1:0] den_ext;
  assign num_w   = sign_q ? (~qn_q + One) : qn_q;
  assign den_ext = rrn_pkg::FieldW'(qd_q);

  always_comb begin
    res_d.num_out = rrn_pkg::FieldW'($signed(num_w));
    res_d.den_out = den_ext[rrn_pkg::DenOutW-1:0];
    res_d.status  = (qd_q == One) ? rrn_pkg::ST_INT : rrn_pkg::ST_RAT;
    if (dz_q) begin
      res_d.num_out = '0;
      res_d.den_out = '0;
      res_d.status  = rrn_pkg::ST_ZERO_DEN;
    end else if (nz_q) begin
      res_d.num_out = '0;
      res_d.den_out = rrn_pkg::DenOutW'(1);
      res_d.status  = rrn_pkg::ST_INT;
    end else if (qn_q == SignBit || qd_q == SignBit) begin
      res_d.num_out = '0;
      res_d.den_out = '0;
      res_d.status  = rrn_pkg::ST_UNREP;
    end
  end

  assign out_o = res_q;

endmodule

// ===== design/rational_reduce_normalize_top.sv =====
// ----------------------------------------------------------------------------
// rational_reduce_normalize_top
// Reduces a signed fraction to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_i and raise start; the beat is taken at the clock edge where
//   start is high and busy is low. busy then stays high until the result has
//   been shown. The result sits on out_o for exactly one cycle with strobe_o
//   high; the receiver cannot stall, so it must take it in that cycle.
//   After the accept the sequencer checks for a zero operand, strips the
//   shared trailing zeros, then the further trailing zeros of the numerator,
//   and runs the subtract/shift binary gcd loop, one step per cycle; each
//   subtract leaves b even. The bit-serial restoring dividers (numerator and
//   denominator in parallel) then divide the shifted operands by the odd gcd,
//   and the result is captured and shown. Zero numerator or zero denominator
//   skips straight from the check to the result capture. busy falls in the
//   cycle after the strobe, so the next beat can be accepted in that cycle.
//   Reset returns the sequencer to idle; any beat in progress is dropped
//   and no strobe is issued for it.
// ----------------------------------------------------------------------------
`include "rational_reduce_normalize_top_macros.svh"

module rational_reduce_normalize_top #(
  parameter int unsigned WIDTH = rrn_pkg::DefaultWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  rrn_pkg::rrn_in_t  in_i,
  output logic              busy,
  output logic              strobe_o,
  output rrn_pkg::rrn_out_t out_o
);

  rrn_pkg::rrn_cmd_t  cmd;
  rrn_pkg::rrn_stat_t stat;

  rrn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .strobe_o (strobe_o)
  );

  rrn_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

  `RRN_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `RRN_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, strobe_o, !strobe_o && !busy)
  `RRN_ASSERT_NOW(a_strobe_busy, clk_i, rst_ni, strobe_o, busy)
  `RRN_ASSERT_NOW(a_err_zero, clk_i, rst_ni,
    strobe_o && (out_o.status == rrn_pkg::ST_ZERO_DEN || out_o.status == rrn_pkg::ST_UNREP),
    out_o.num_out == '0 && out_o.den_out == '0)

endmodule
